// File: rtl/rcpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_pkg: shared types and constants of the RC pulse width decoder
// Field widths, configuration register codes and reset values, and the
// control bundle that the pipeline control hands to every channel lane.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

	localparam int REF_FIELDS  = 4;
	localparam int LEVEL_W     = 4;
	localparam int OFFSET_W    = 10;
	localparam int GAIN_W      = 4;
	localparam int PERIOD_W    = 11;
	localparam int REF_W       = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;

	localparam logic [PERIOD_W-1:0] WRAP_PERIOD_RST = PERIOD_W'(1000);
	localparam logic [OFFSET_W-1:0] OFFSET_STD_RST  = OFFSET_W'(150);
	localparam logic [OFFSET_W-1:0] OFFSET_CH2_RST  = OFFSET_W'(110);
	localparam logic [GAIN_W-1:0]   GAIN_RST        = GAIN_W'(10);
	localparam logic [LEVEL_W-1:0]  INVERT_MASK_RST = LEVEL_W'(8);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_WRAP_PERIOD = 3'd0,
		CFG_OFFSET_CH0  = 3'd1,
		CFG_OFFSET_CH1  = 3'd2,
		CFG_OFFSET_CH2  = 3'd3,
		CFG_OFFSET_CH3  = 3'd4,
		CFG_GAIN        = 3'd5,
		CFG_INVERT_MASK = 3'd6
	} cfg_idx_t;

	// accept: a request enters stage 1; load: stage 1 moves into the output stage.
	typedef struct packed {
		logic accept;
		logic load;
	} lane_ctrl_t;

endpackage

// File: rtl/rcpwm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_lane: one channel of the pulse width decoder
// Stage 1 detects edges, stores the pulse start and forms the wrapped width.
// Stage 2 scales the width by offset and gain, optionally negates it and
// saturates it into the held reference.
// ----------------------------------------------------------------------------
module rcpwm_lane
	import rcpwm_pkg::*;
#(
	parameter int TIME_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctrl_t                 ctrl,
	input  logic                       level,
	input  logic [TIME_BITS-1:0]       ts,
	input  logic [TIME_BITS:0]         period,
	input  logic [OFFSET_W-1:0]        offset,
	input  logic [GAIN_W-1:0]          gain,
	input  logic                       invert,
	output logic                       fall,
	output logic signed [REF_W-1:0]    held_ref
);

	localparam int WW = ((TIME_BITS + 1) > OFFSET_W ? (TIME_BITS + 1) : OFFSET_W) + 1;
	localparam int PW = WW + GAIN_W + 1;
	localparam int NW = PW + 1;
	localparam logic signed [NW-1:0] SAT_MAX = NW'(32767);
	localparam logic signed [NW-1:0] SAT_MIN = -NW'(32768);

	logic                        last_q;
	logic [TIME_BITS-1:0]        start_q;
	logic                        fall_s1;
	logic signed [TIME_BITS:0]   width_s1;
	logic signed [REF_W-1:0]     held_q;

	logic signed [TIME_BITS+1:0] diff;
	logic signed [TIME_BITS+1:0] wrapped;
	logic signed [TIME_BITS:0]   width_d;
	logic signed [WW-1:0]        corr;
	logic signed [PW-1:0]        prod;
	logic signed [NW-1:0]        signed_val;
	logic signed [REF_W-1:0]     sat_val;

	// A start stored under a larger period can stay negative after the wrap.
	always_comb begin
		diff    = $signed({2'b00, ts}) - $signed({2'b00, start_q});
		wrapped = diff + $signed({1'b0, period});
		width_d = diff[TIME_BITS+1] ? wrapped[TIME_BITS:0] : diff[TIME_BITS:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			start_q <= '0;
			fall_s1 <= 1'b0;
		end else if (ctrl.accept) begin
			fall_s1 <= last_q && !level;
			if (level && !last_q) begin
				start_q <= ts;
			end
			last_q <= level;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && last_q && !level) begin
			width_s1 <= width_d;
		end
	end

	always_comb begin
		corr = $signed({{(WW-TIME_BITS-1){width_s1[TIME_BITS]}}, width_s1})
			- $signed({{(WW-OFFSET_W){1'b0}}, offset});
		prod = $signed({{(PW-WW){corr[WW-1]}}, corr})
			* $signed({{(PW-GAIN_W){1'b0}}, gain});
		signed_val = invert ? -$signed({prod[PW-1], prod}) : $signed({prod[PW-1], prod});
		if (signed_val > SAT_MAX) begin
			sat_val = SAT_MAX[REF_W-1:0];
		end else if (signed_val < SAT_MIN) begin
			sat_val = SAT_MIN[REF_W-1:0];
		end else begin
			sat_val = signed_val[REF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ctrl.load && fall_s1) begin
			held_q <= sat_val;
		end
	end

	assign fall     = fall_s1;
	assign held_ref = held_q;

endmodule

// File: rtl/rcpwm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_merge: pipeline control and lane merge
// Tracks the two pipeline stages, issues the lane controls and gathers the
// per-lane falling-edge flags into the registered update mask.
// ----------------------------------------------------------------------------
module rcpwm_merge
	import rcpwm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic [REF_FIELDS-1:0] fall,
	output lane_ctrl_t            ctrl,
	output logic [LEVEL_W-1:0]    updated_mask
);

	logic                  s1_valid_q;
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    mask_q;
	logic                  s1_adv;

	// The output stage frees up in the same cycle its result is taken.
	assign s1_adv      = !out_valid_q || out_ready;
	assign in_ready    = !s1_valid_q || s1_adv;
	assign ctrl.accept = in_valid && in_ready;
	assign ctrl.load   = s1_valid_q && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mask_q      <= '0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q;
			end
			if (ctrl.load) begin
				mask_q <= LEVEL_W'(fall);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign updated_mask = mask_q;

endmodule

// File: rtl/rc_pwm_pulse_width_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_decoder_unit: four-channel RC receiver pulse decoder
// Measures pulse widths on the pin levels and turns them into scaled,
// saturated 16-bit references held per channel.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled, and
// returns one result per request, registered in stage 1 and then stage 2. Each
// channel has its own lane: stage 1 finds edges and the wrapped pulse width,
// stage 2 applies offset and gain and holds the reference, which is the
// output register itself. Edge history lives in stage 1, so throughput is
// set by the stage 1 update of a lane: one request per cycle unless stalled.
// Configuration writes take effect on the next cycle and are meant for an idle block.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_decoder_unit
	import rcpwm_pkg::*;
#(
	parameter int CHANNELS  = 4,
	parameter int TIME_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [LEVEL_W-1:0]         pin_levels,
	input  logic [TIME_BITS-1:0]       timestamp,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [REF_W-1:0]    ref_ch0,
	output logic signed [REF_W-1:0]    ref_ch1,
	output logic signed [REF_W-1:0]    ref_ch2,
	output logic signed [REF_W-1:0]    ref_ch3,
	output logic [LEVEL_W-1:0]         updated_mask
);

	localparam int LANES = (CHANNELS < REF_FIELDS) ? CHANNELS : REF_FIELDS;
	localparam int CW    = (PERIOD_W > TIME_BITS + 1) ? PERIOD_W : TIME_BITS + 1;
	localparam logic [CW-1:0] PMIN = CW'(2);
	localparam logic [CW-1:0] PMAX = CW'(1) << TIME_BITS;

	logic [PERIOD_W-1:0]   wrap_period_q;
	logic [OFFSET_W-1:0]   offset_q [REF_FIELDS];
	logic [GAIN_W-1:0]     gain_q;
	logic [LEVEL_W-1:0]    invert_mask_q;

	logic [CW-1:0]         wrap_ext;
	logic [CW-1:0]         period_c;
	logic [TIME_BITS:0]    period_eff;
	logic [TIME_BITS:0]    period_m1;
	logic [TIME_BITS-1:0]  ts_clamped;

	lane_ctrl_t              ctrl;
	logic [REF_FIELDS-1:0]   fall;
	logic signed [REF_W-1:0] refs [REF_FIELDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_period_q <= WRAP_PERIOD_RST;
			offset_q[0]   <= OFFSET_STD_RST;
			offset_q[1]   <= OFFSET_STD_RST;
			offset_q[2]   <= OFFSET_CH2_RST;
			offset_q[3]   <= OFFSET_STD_RST;
			gain_q        <= GAIN_RST;
			invert_mask_q <= INVERT_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WRAP_PERIOD: wrap_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_OFFSET_CH0:  offset_q[0]   <= cfg_data[OFFSET_W-1:0];
				CFG_OFFSET_CH1:  offset_q[1]   <= cfg_data[OFFSET_W-1:0];
				CFG_OFFSET_CH2:  offset_q[2]   <= cfg_data[OFFSET_W-1:0];
				CFG_OFFSET_CH3:  offset_q[3]   <= cfg_data[OFFSET_W-1:0];
				CFG_GAIN:        gain_q        <= cfg_data[GAIN_W-1:0];
				CFG_INVERT_MASK: invert_mask_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range periods are pinned to 2..2^TIME_BITS, and timestamps at
	// or beyond the period read as the last tick of the period.
	always_comb begin
		wrap_ext = CW'(wrap_period_q);
		if (wrap_ext < PMIN) begin
			period_c = PMIN;
		end else if (wrap_ext > PMAX) begin
			period_c = PMAX;
		end else begin
			period_c = wrap_ext;
		end
		period_eff = period_c[TIME_BITS:0];
		period_m1  = period_eff - (TIME_BITS+1)'(1);
		ts_clamped = ({1'b0, timestamp} >= period_eff) ? period_m1[TIME_BITS-1:0] : timestamp;
	end

	rcpwm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fall         (fall),
		.ctrl         (ctrl),
		.updated_mask (updated_mask)
	);

	for (genvar i = 0; i < REF_FIELDS; i++) begin : g_lane
		if (i < LANES) begin : g_on
			rcpwm_lane #(
				.TIME_BITS (TIME_BITS)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.level    (pin_levels[i]),
				.ts       (ts_clamped),
				.period   (period_eff),
				.offset   (offset_q[i]),
				.gain     (gain_q),
				.invert   (invert_mask_q[i]),
				.fall     (fall[i]),
				.held_ref (refs[i])
			);
		end else begin : g_off
			assign fall[i] = 1'b0;
			assign refs[i] = '0;
		end
	end

	assign ref_ch0 = refs[0];
	assign ref_ch1 = refs[1];
	assign ref_ch2 = refs[2];
	assign ref_ch3 = refs[3];

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !in_ready |=> out_valid)
		else $error("output dropped while stage 1 still held a request");

	a_ref_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ref_ch0) |-> updated_mask[0])
		else $error("channel 0 reference changed without an update");
`endif

endmodule

// File: bench/rcpwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_checker: result predictor and scoreboard for the RC pulse decoder
// Watches the configuration port and both request channels, keeps its own
// copy of the edge history, pulse starts and held references, and compares
// every result field by field against the oldest predicted frame.
// ----------------------------------------------------------------------------
module rcpwm_checker
	import rcpwm_pkg::*;
#(
	parameter int TIME_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [LEVEL_W-1:0]         pin_levels,
	input  logic [TIME_BITS-1:0]       timestamp,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [REF_W-1:0]    ref_ch0,
	input  logic signed [REF_W-1:0]    ref_ch1,
	input  logic signed [REF_W-1:0]    ref_ch2,
	input  logic signed [REF_W-1:0]    ref_ch3,
	input  logic [LEVEL_W-1:0]         updated_mask,
	output int                         mismatches,
	output int                         results_owed
);

	typedef struct packed {
		logic [REF_FIELDS-1:0][REF_W-1:0] refs;
		logic [LEVEL_W-1:0]               upd;
	} ref_frame_t;

	logic [PERIOD_W-1:0]     period_reg;
	logic [OFFSET_W-1:0]     offset_reg [REF_FIELDS];
	logic [GAIN_W-1:0]       gain_reg;
	logic [LEVEL_W-1:0]      invert_reg;
	logic [LEVEL_W-1:0]      level_hist;
	logic [TIME_BITS-1:0]    start_stamp [REF_FIELDS];
	logic signed [REF_W-1:0] ref_hold [REF_FIELDS];
	ref_frame_t              frame_q [$];

	// Applies one request to the shadow state and returns the frame it produces.
	function automatic ref_frame_t decode_edges(input logic [LEVEL_W-1:0] lv,
			input logic [TIME_BITS-1:0] ts_in);
		int span;
		int stamp;
		int width;
		int scaled;
		int ch;
		ref_frame_t frame;
		span = int'(period_reg);
		if (span < 2)
			span = 2;
		if (span > (1 << TIME_BITS))
			span = 1 << TIME_BITS;
		stamp = int'(ts_in);
		if (stamp >= span)
			stamp = span - 1;
		frame.upd = '0;
		for (ch = 0; ch < REF_FIELDS; ch++) begin
			if (lv[ch] != level_hist[ch]) begin
				if (level_hist[ch]) begin
					// A start left over from a longer period may still be negative here.
					width = stamp - int'(start_stamp[ch]);
					if (width < 0)
						width += span;
					scaled = (width - int'(offset_reg[ch])) * int'(gain_reg);
					if (invert_reg[ch])
						scaled = -scaled;
					if (scaled > 32767)
						scaled = 32767;
					else if (scaled < -32768)
						scaled = -32768;
					ref_hold[ch] = scaled[REF_W-1:0];
					frame.upd[ch] = 1'b1;
				end else begin
					start_stamp[ch] = stamp[TIME_BITS-1:0];
				end
			end
			frame.refs[ch] = ref_hold[ch];
		end
		level_hist = lv;
		return frame;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ref_frame_t want;
		ref_frame_t got;
		int ch;
		if (!arst_n) begin
			period_reg = WRAP_PERIOD_RST;
			offset_reg[0] = OFFSET_STD_RST;
			offset_reg[1] = OFFSET_STD_RST;
			offset_reg[2] = OFFSET_CH2_RST;
			offset_reg[3] = OFFSET_STD_RST;
			gain_reg = GAIN_RST;
			invert_reg = INVERT_MASK_RST;
			level_hist = '0;
			for (ch = 0; ch < REF_FIELDS; ch++) begin
				start_stamp[ch] = '0;
				ref_hold[ch] = '0;
			end
			frame_q.delete();
			mismatches = 0;
			results_owed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WRAP_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
					CFG_OFFSET_CH0:  offset_reg[0] = cfg_data[OFFSET_W-1:0];
					CFG_OFFSET_CH1:  offset_reg[1] = cfg_data[OFFSET_W-1:0];
					CFG_OFFSET_CH2:  offset_reg[2] = cfg_data[OFFSET_W-1:0];
					CFG_OFFSET_CH3:  offset_reg[3] = cfg_data[OFFSET_W-1:0];
					CFG_GAIN:        gain_reg = cfg_data[GAIN_W-1:0];
					CFG_INVERT_MASK: invert_reg = cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.refs = {ref_ch3, ref_ch2, ref_ch1, ref_ch0};
				got.upd = updated_mask;
				if (frame_q.size() == 0) begin
					$error("result with no request pending: updated_mask %b", got.upd);
					mismatches++;
				end else begin
					want = frame_q.pop_front();
					for (ch = 0; ch < REF_FIELDS; ch++) begin
						if (got.refs[ch] !== want.refs[ch]) begin
							$error("ref_ch%0d: expected %0d, got %0d", ch,
								$signed(want.refs[ch]), $signed(got.refs[ch]));
							mismatches++;
						end
					end
					if (got.upd !== want.upd) begin
						$error("updated_mask: expected %b, got %b", want.upd, got.upd);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				frame_q.push_back(decode_edges(pin_levels, timestamp));
			results_owed = frame_q.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the RC pulse width decoder
// Drives directed edge patterns, a receiver hold-off and several phases of
// randomized pulse trains under different register settings and pacing;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import rcpwm_pkg::*;

	localparam int STAMP_W        = 10;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 245;
	localparam int PHASES         = 7;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [LEVEL_W-1:0]      pin_levels = '0;
	logic [STAMP_W-1:0]      timestamp = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [REF_W-1:0] ref_ch0;
	logic signed [REF_W-1:0] ref_ch1;
	logic signed [REF_W-1:0] ref_ch2;
	logic signed [REF_W-1:0] ref_ch3;
	logic [LEVEL_W-1:0]      updated_mask;

	int                      mismatches;
	int                      results_owed;
	int                      send_idle_pct = 0;
	int                      stall_pct = 0;
	logic                    hold_request = 1'b0;
	int                      hold_left = 0;
	int                      quiet_cycles = 0;
	int                      cur_period = 1000;
	int                      tick = 0;
	logic [LEVEL_W-1:0]      drive_levels = '0;

	rc_pwm_pulse_width_decoder_unit #(
		.CHANNELS  (4),
		.TIME_BITS (STAMP_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pin_levels   (pin_levels),
		.timestamp    (timestamp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ref_ch0      (ref_ch0),
		.ref_ch1      (ref_ch1),
		.ref_ch2      (ref_ch2),
		.ref_ch3      (ref_ch3),
		.updated_mask (updated_mask)
	);

	rcpwm_checker #(
		.TIME_BITS (STAMP_W)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pin_levels   (pin_levels),
		.timestamp    (timestamp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ref_ch0      (ref_ch0),
		.ref_ch1      (ref_ch1),
		.ref_ch2      (ref_ch2),
		.ref_ch3      (ref_ch3),
		.updated_mask (updated_mask),
		.mismatches   (mismatches),
		.results_owed (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, or one long hold-off so the pipeline backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL:       begin send_idle_pct = 0;  stall_pct = 0;  end
			PACE_SEND_IDLE:  begin send_idle_pct = 79; stall_pct = 0;  end
			PACE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 79; end
			default:         begin send_idle_pct = 18; stall_pct = 18; end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic push_request(input logic [LEVEL_W-1:0] lv, input logic [STAMP_W-1:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pin_levels <= lv;
		timestamp <= ts;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_all(input int per, input int o0, input int o1, input int o2,
			input int o3, input int g, input int inv);
		logic [CFG_DATA_W-1:0] per_bits;
		per_bits = per[CFG_DATA_W-1:0];
		write_reg(CFG_WRAP_PERIOD, per_bits);
		write_reg(CFG_OFFSET_CH0, o0[CFG_DATA_W-1:0]);
		write_reg(CFG_OFFSET_CH1, o1[CFG_DATA_W-1:0]);
		write_reg(CFG_OFFSET_CH2, o2[CFG_DATA_W-1:0]);
		write_reg(CFG_OFFSET_CH3, o3[CFG_DATA_W-1:0]);
		write_reg(CFG_GAIN, g[CFG_DATA_W-1:0]);
		write_reg(CFG_INVERT_MASK, inv[CFG_DATA_W-1:0]);
		cfg_we <= 1'b0;
		cur_period = int'(per_bits);
		if (cur_period < 2)
			cur_period = 2;
		if (cur_period > (1 << STAMP_W))
			cur_period = 1 << STAMP_W;
		tick = tick % cur_period;
	endtask

	task automatic program_phase(input int p);
		case (p)
			1: load_all(2047, 2047, 2047, 2047, 2047, 2047, 2047);
			2: begin
				load_all(0, 0, 0, 0, 0, 0, 0);
				// Writes outside the register list must leave everything alone.
				write_reg(CFG_SPARE_INDEX, 11'h7FF);
				cfg_we <= 1'b0;
			end
			3: load_all(1, $urandom_range(1023), $urandom_range(1023),
				$urandom_range(1023), $urandom_range(1023), 1, 5);
			4: load_all(1024, $urandom_range(300), $urandom_range(300),
				$urandom_range(300), $urandom_range(300), 15, 10);
			5: load_all($urandom_range(1024, 2), $urandom_range(1023), $urandom_range(1023),
				$urandom_range(1023), $urandom_range(1023), $urandom_range(15),
				$urandom_range(15));
			6: load_all($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
				$urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
				$urandom_range(2047));
			default: ;
		endcase
	endtask

	// Mostly pulse trains with a timestamp that runs forward and wraps, some noise.
	task automatic run_traffic(input int p, input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if (n % 50 == 0)
				set_pace(pace_t'((n / 50 + p) % 4));
			if ($urandom_range(9) == 0) begin
				drive_levels = LEVEL_W'($urandom_range(15));
				push_request(drive_levels, STAMP_W'($urandom_range(1023)));
			end else begin
				tick = (tick + $urandom_range(60, 1)) % cur_period;
				drive_levels = drive_levels ^ (LEVEL_W'($urandom_range(15))
					& LEVEL_W'($urandom_range(15)));
				push_request(drive_levels, tick[STAMP_W-1:0]);
			end
		end
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FULL);
		push_request(4'h0, 10'd0);
		push_request(4'hF, 10'd100);
		push_request(4'hF, 10'd250);
		push_request(4'hE, 10'd250);
		push_request(4'hC, 10'd400);
		push_request(4'h8, 10'd999);
		// Timestamp beyond the period is clamped to period minus one.
		push_request(4'h0, 10'd1023);
		push_request(4'h1, 10'd990);
		// The falling edge lands after the counter wrapped.
		push_request(4'h0, 10'd5);
		push_request(4'hF, 10'd1023);
		push_request(4'h0, 10'd0);
		push_request(4'h5, 10'd512);
		push_request(4'hA, 10'd700);
		push_request(4'h0, 10'd1000);
		push_request(4'hF, 10'h2AA);
		push_request(4'h0, 10'h155);

		// Long receiver hold-off while requests keep coming.
		hold_request <= 1'b1;
		push_request(4'h3, 10'd10);
		hold_request <= 1'b0;
		for (int k = 0; k < 20; k++)
			push_request(LEVEL_W'(k), STAMP_W'(k * 37));
		drive_levels = 4'h0;

		for (p = 0; p < PHASES; p++) begin
			wait_drained();
			program_phase(p);
			// Falling edges right after a period change may see a stale start.
			push_request(4'h0, 10'd1);
			drive_levels = 4'h0;
			run_traffic(p, PHASE_ITEMS);
			push_request(4'h0, tick[STAMP_W-1:0]);
			push_request(4'hF, 10'h3FF);
		end

		wait_drained();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
